// File: rtl/core/egacc_pkg.sv
// Shared constants and types of the embedding gradient accumulator.
`timescale 1ns / 1ps
package egacc_pkg;

    // Opcodes of a request.
    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ROW_ERR = 2'd1;
    localparam logic [1:0] ST_COL_ERR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PADDING_ROW = 2'd0;
    localparam logic [1:0] CFG_SCALE       = 2'd1;
    localparam logic [1:0] CFG_ROWS        = 2'd2;
    localparam logic [1:0] CFG_COLUMNS     = 2'd3;

    // Field and store widths fixed by the request format.
    localparam int SUM_W  = 48;
    localparam int GRAD_W = 32;
    localparam int CFG_W  = 9;

    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [GRAD_W-1:0] grad_t;

endpackage

// File: rtl/core/egacc_if.sv
// Request and result channel interfaces of the embedding gradient accumulator.
`timescale 1ns / 1ps
interface egacc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [7:0]        row_index;
    logic [5:0]        column;
    logic signed [31:0] grad_value;

    modport source (output valid, opcode, row_index, column, grad_value, input ready);
    modport sink   (input valid, opcode, row_index, column, grad_value, output ready);
endinterface

interface egacc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] grad_out;
    logic [1:0]         status;

    modport source (output valid, grad_out, status, input ready);
    modport sink   (input valid, grad_out, status, output ready);
endinterface

// File: rtl/core/egacc_ram.sv
// Generic single write, single read port RAM with registered read data.
`timescale 1ns / 1ps
module egacc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/egacc_div.sv
// Bit-serial restoring divider: 48-bit magnitude by an unsigned count.
`timescale 1ns / 1ps
module egacc_div #(
    parameter int COUNT_BITS = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [47:0]           dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  done,
    output logic [47:0]           quotient
);
    import egacc_pkg::*;

    logic [47:0]           quo_reg, quo_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dvs_reg, dvs_next;
    logic [5:0]            step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;

    // One quotient bit per cycle.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = 6'd47;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[COUNT_BITS])
            begin
                rem_next = shifted[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            step_next = step_reg - 6'd1;
            if (step_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: rtl/core/embedding_grad_accumulator_core.sv
// Top level of the embedding gradient accumulator.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | opcode, row_index, column, grad_value
//  out_ch  | out | valid/ready   | grad_out, status
//  cfg     | in  | cfg_we only   | cfg_index, cfg_wdata
//
// Accumulate and unscaled read requests pass through the lookup, execute and finish steps;
// error and unused-opcode requests go from lookup straight to finish, and a scaled read
// adds the divide and sign steps, the divide step waiting on the one-bit-per-cycle divider.
// A clear request sweeps the sum store, all MAX_ROWS*MAX_COLUMNS entries, then finishes.
// After reset the same sweep runs before in_ch is ready.
// A new request is taken while an earlier result waits in the output register.
`timescale 1ns / 1ps
module embedding_grad_accumulator_core #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 64,
    parameter int COUNT_BITS  = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    egacc_in_if.sink                  in_ch,
    egacc_out_if.source               out_ch,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [egacc_pkg::CFG_W-1:0] cfg_wdata
);
    import egacc_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLR_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SIGN  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CLR_W-1:0]      clr_reg, clr_next;
    logic signed [8:0]     pad_reg;
    logic                  scale_reg;
    logic [8:0]            rows_reg;
    logic [6:0]            cols_reg;
    logic [1:0]            op_reg;
    logic [7:0]            row_reg;
    logic [5:0]            col_reg;
    grad_t                 gin_reg;
    grad_t                 res_reg, res_next;
    logic [1:0]            st_reg, st_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg;
    grad_t                 out_grad_reg;
    logic [1:0]            out_st_reg;
    logic                  accept;
    logic                  out_load;

    logic [ADDR_W-1:0]     item_addr;
    logic [ROW_W-1:0]      item_row;
    logic                  sum_we;
    logic [ADDR_W-1:0]     sum_waddr;
    logic [SUM_W-1:0]      sum_wdata;
    logic [SUM_W-1:0]      sum_rdata;
    logic                  cnt_we;
    logic [ROW_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;

    logic [SUM_W:0]        sum_add;
    logic [SUM_W-1:0]      sum_sat;
    logic [SUM_W-1:0]      sum_mag;
    logic                  row_ok;
    logic                  col_ok;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      quotient;

    assign accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    // Store addresses of the current request.
    assign item_row  = ROW_W'(row_reg);
    assign item_addr = ADDR_W'(ADDR_W'(item_row) * ADDR_W'(MAX_COLUMNS)
                       + ADDR_W'(COL_W'(col_reg)));

    // Range checks against the limits in use and the store size.
    assign row_ok = (32'(row_reg) < 32'(rows_reg)) && (32'(row_reg) < MAX_ROWS);
    assign col_ok = (32'(col_reg) < 32'(cols_reg)) && (32'(col_reg) < MAX_COLUMNS);

    // Saturating 48-bit accumulate.
    assign sum_add = {sum_rdata[SUM_W-1], sum_rdata} + (SUM_W+1)'(signed'(gin_reg));
    always_comb
    begin
        if (sum_add[SUM_W] != sum_add[SUM_W-1])
        begin
            sum_sat = {sum_add[SUM_W], {(SUM_W-1){~sum_add[SUM_W]}}};
        end
        else
        begin
            sum_sat = sum_add[SUM_W-1:0];
        end
    end
    assign sum_mag = sum_rdata[SUM_W-1] ? (~sum_rdata + 1'b1) : sum_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg   <= -9'sd1;
            scale_reg <= 1'b0;
            rows_reg  <= 9'd256;
            cols_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PADDING_ROW: pad_reg   <= signed'(cfg_wdata);
                CFG_SCALE:       scale_reg <= cfg_wdata[0];
                CFG_ROWS:        rows_reg  <= cfg_wdata;
                CFG_COLUMNS:     cols_reg  <= cfg_wdata[6:0];
                default:         ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        neg_next   = neg_reg;
        sum_we     = 1'b0;
        sum_waddr  = item_addr;
        sum_wdata  = sum_sat;
        cnt_we     = 1'b0;
        cnt_waddr  = item_row;
        cnt_wdata  = cnt_rdata + 1'b1;
        div_start  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = ADDR_W'(clr_reg);
                sum_wdata = '0;
                cnt_we    = (32'(clr_reg) < MAX_ROWS);
                cnt_waddr = ROW_W'(clr_reg);
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1)
                begin
                    state_next = (op_reg == OP_CLEAR) ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                res_next   = '0;
                st_next    = ST_OK;
                state_next = S_FIN;
                if (op_reg == OP_CLEAR)
                begin
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                else if (op_reg == OP_ACCUM || op_reg == OP_READ)
                begin
                    if (!row_ok)
                    begin
                        st_next = ST_ROW_ERR;
                    end
                    else if (!col_ok)
                    begin
                        st_next = ST_COL_ERR;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                if (op_reg == OP_ACCUM)
                begin
                    sum_we = 1'b1;
                    cnt_we = (col_reg == 6'd0) && (cnt_rdata != '1);
                end
                else if ((signed'({1'b0, row_reg}) != pad_reg) && (cnt_rdata != '0))
                begin
                    neg_next = sum_rdata[SUM_W-1];
                    if (scale_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        // Saturate the raw sum to 32 bits.
                        if (sum_rdata[SUM_W-1:GRAD_W-1] == '0 ||
                            sum_rdata[SUM_W-1:GRAD_W-1] == '1)
                        begin
                            res_next = sum_rdata[GRAD_W-1:0];
                        end
                        else
                        begin
                            res_next = {sum_rdata[SUM_W-1], {(GRAD_W-1){~sum_rdata[SUM_W-1]}}};
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                // Restore the sign and saturate the quotient to 32 bits.
                state_next = S_FIN;
                if (neg_reg)
                begin
                    if (quotient > SUM_W'(48'h8000_0000))
                    begin
                        res_next = {1'b1, {(GRAD_W-1){1'b0}}};
                    end
                    else
                    begin
                        res_next = GRAD_W'(~quotient + 1'b1);
                    end
                end
                else if (quotient > SUM_W'(48'h7FFF_FFFF))
                begin
                    res_next = {1'b0, {(GRAD_W-1){1'b1}}};
                end
                else
                begin
                    res_next = quotient[GRAD_W-1:0];
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            op_reg        <= OP_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (accept)
            begin
                op_reg <= in_ch.opcode;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= in_ch.row_index;
            col_reg <= in_ch.column;
            gin_reg <= in_ch.grad_value;
        end
        res_reg <= res_next;
        st_reg  <= st_next;
        neg_reg <= neg_next;
        if (out_load)
        begin
            out_grad_reg <= res_reg;
            out_st_reg   <= st_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.grad_out = out_grad_reg;
    assign out_ch.status   = out_st_reg;

    // Sum and count stores.
    egacc_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_sums (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (item_addr),
        .rdata (sum_rdata)
    );

    egacc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_ROWS), .AW(ROW_W)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (item_row),
        .rdata (cnt_rdata)
    );

    // Divider for count scaling.
    egacc_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_rdata),
        .done     (div_done),
        .quotient (quotient)
    );

    // An accepted request always moves to the lookup step.
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOOK)
        else $error("accepted request did not enter lookup");

    // Error results carry a zero gradient.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.grad_out == '0)
        else $error("error result with nonzero gradient");

    // The divider finishes only while the sequencer waits on it.
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");
endmodule
